FILE: hdl/pbo_pkg.sv
package pbo_pkg;

  // Blend mode codes as held in the blend mode register.
  typedef enum logic [3:0] {
    MODE_NORMAL     = 4'd0,
    MODE_MULTIPLY   = 4'd1,
    MODE_SCREEN     = 4'd2,
    MODE_OVERLAY    = 4'd3,
    MODE_HARD_LIGHT = 4'd4,
    MODE_SOFT_LIGHT = 4'd5,
    MODE_DODGE      = 4'd6,
    MODE_BURN       = 4'd7,
    MODE_LIN_DODGE  = 4'd8,
    MODE_LIN_BURN   = 4'd9,
    MODE_DARKEN     = 4'd10,
    MODE_LIGHTEN    = 4'd11,
    MODE_DIFFERENCE = 4'd12,
    MODE_EXCLUSION  = 4'd13
  } blend_mode_e;

  localparam int CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BLEND_MODE    = 2'd0,
    CFG_LAYER_OPACITY = 2'd1,
    CFG_FILL_OPACITY  = 2'd2
  } cfg_index_e;

  typedef struct packed {
    logic [7:0] src_red;
    logic [7:0] src_green;
    logic [7:0] src_blue;
    logic [7:0] src_alpha;
    logic [7:0] dst_red;
    logic [7:0] dst_green;
    logic [7:0] dst_blue;
    logic [7:0] dst_alpha;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       changed;
  } pix_out_t;

  // Long divider geometry: one quotient bit per stage.
  localparam int DivNumW   = 40;
  localparam int DivDenW   = 32;
  localparam int DivStages = 8;

  // Front stages, blend divider, composite stages, final divider.
  localparam int PipeDepth = 13 + 3 + DivStages;

  localparam logic [23:0] CUBE       = 24'd16581375;  // 255^3
  localparam logic [31:0] SOFT_DEN   = 32'd16711680;  // 255 * 65536
  localparam logic [31:0] SQ255      = 32'd65025;     // 255^2
  localparam logic [39:0] SQ255_BIAS = 40'd65024;     // turns a floor into a ceiling

  typedef logic [255:0][16:0] root_tab_t;

  // Q1.16 square root of a/255 for every 8-bit a, built at elaboration.
  function automatic root_tab_t build_root_tab();
    root_tab_t       tab;
    longint unsigned v;
    longint unsigned r;
    longint unsigned bt;
    for (int a = 0; a < 256; a++) begin
      v  = (longint'(a) << 32) / 255;
      r  = 0;
      bt = 64'd1 << 32;
      while (bt > v) bt = bt >> 2;
      while (bt != 0) begin
        if (v >= r + bt) begin
          v = v - (r + bt);
          r = (r >> 1) + bt;
        end else begin
          r = r >> 1;
        end
        bt = bt >> 2;
      end
      tab[a] = r[16:0];
    end
    return tab;
  endfunction

  localparam root_tab_t ROOT_TAB = build_root_tab();

endpackage

FILE: hdl/pbo_if.sv
interface pbo_pix_in_if;
  logic              valid;
  logic              ready;
  pbo_pkg::pix_in_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pbo_pix_out_if;
  logic              valid;
  logic              ready;
  pbo_pkg::pix_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pbo_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [pbo_pkg::CfgIdxW-1:0]  index;
  logic [7:0]                   data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hdl/pbo_div.sv
// Pipelined restoring divider. The quotient is known to fit in DivStages
// bits unless sat_o is set, which flags num >= den * 2^DivStages.
module pbo_div (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [pbo_pkg::DivNumW-1:0]  num_i,
  input  logic [pbo_pkg::DivDenW-1:0]  den_i,
  output logic [pbo_pkg::DivStages-1:0] quo_o,
  output logic                         sat_o
);

  localparam int NW = pbo_pkg::DivNumW;
  localparam int DW = pbo_pkg::DivDenW;
  localparam int NS = pbo_pkg::DivStages;

  logic [NW-1:0] rem_q [NS];
  logic [DW-1:0] den_q [NS];
  logic [NS-1:0] quo_q [NS];
  logic          sat_q [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [NW-1:0] rem_in;
    logic [NW-1:0] dsh;
    logic [DW-1:0] den_in;
    logic [NS-1:0] quo_in;
    logic [NS-1:0] quo_d;
    logic          sat_in;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
      assign sat_in = num_i >= {den_i, {NS{1'b0}}};
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
      assign sat_in = sat_q[k-1];
    end

    assign dsh = NW'(den_in) << (NS - 1 - k);
    assign ge  = rem_in >= dsh;

    always_comb begin
      quo_d             = quo_in;
      quo_d[NS - 1 - k] = ge;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? rem_in - dsh : rem_in;
        den_q[k] <= den_in;
        quo_q[k] <= quo_d;
        sat_q[k] <= sat_in;
      end
    end
  end

  assign quo_o = quo_q[NS-1];
  assign sat_o = sat_q[NS-1];

endmodule

FILE: hdl/pixel_blend_over_composite.sv
// Channel   Dir  Handshake      Payload
// cfg_i     in   valid/ready    index (2 bits), data (8 bits); ready is always high
// pix_i     in   valid/ready    source RGBA and destination RGBA, 8 bits each
// pix_o     out  valid/ready    new destination RGBA and the changed flag
//
// One request is taken every clock while the output is not stalled.
// The pipeline has 24 register stages: the input register, four operand stages,
// the 8-stage blend divider, three composite stages and the 8-stage final divider.
// Reset is asynchronous; it clears the valid bits and returns the configuration
// registers to their reset values (normal mode, both opacities at 255).
// The whole pipeline advances together; while the output request waits, every
// stage holds, and the input is ready again as soon as the output is taken.

module pixel_blend_over_composite (
  input  logic             clk_i,
  input  logic             rst_ni,
  pbo_cfg_if.sink          cfg_i,
  pbo_pix_in_if.sink       pix_i,
  pbo_pix_out_if.source    pix_o
);

  localparam int LAT = pbo_pkg::PipeDepth;
  localparam int NS  = pbo_pkg::DivStages;

  // Side data that rides alongside the blend divider.
  typedef struct packed {
    logic [2:0][7:0] dst;
    logic [2:0][7:0] src;
    logic [7:0]      da;
    logic            az;
    logic [31:0]     s255;
    logic [31:0]     dks;
  } side_t;

  // Side data that rides alongside the composite divider.
  typedef struct packed {
    logic [2:0][7:0] dst;
    logic [7:0]      da;
    logic            skip;
  } fin_t;

  typedef struct packed {
    logic [39:0] num;
    logic [31:0] den;
  } div_req_t;

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes must arrive only while the pipeline is empty; the block does not enforce this.
  // ---------------------------------------------------------------------------
  logic [3:0] mode_q;
  logic [7:0] layer_q;
  logic [7:0] fill_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= pbo_pkg::MODE_NORMAL;
      layer_q <= 8'd255;
      fill_q  <= 8'd255;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        pbo_pkg::CFG_BLEND_MODE:    mode_q  <= cfg_i.data[3:0];
        pbo_pkg::CFG_LAYER_OPACITY: layer_q <= cfg_i.data;
        pbo_pkg::CFG_FILL_OPACITY:  fill_q  <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Global advance. Valid bits travel in step with the data registers.
  // ---------------------------------------------------------------------------
  logic [LAT-1:0] v_q;
  logic           en;

  assign en          = !v_q[LAT-1] || pix_o.ready;
  assign pix_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[LAT-2:0], pix_i.valid};
    end
  end

  // Maps the blend mode onto one request for the shared long divider.
  // Every mode that needs a division, including the x*y/255 of the
  // multiply family, goes through the same unit.
  function automatic div_req_t blend_req(input logic [3:0] mode, input logic [7:0] a,
                                         input logic [7:0] b, input logic [15:0] prod,
                                         input logic [21:0] t, input logic [31:0] x2,
                                         input logic [29:0] x3);
    div_req_t req;
    req.num = 40'(prod);
    req.den = 32'd255;
    unique case (mode)
      pbo_pkg::MODE_DODGE: begin
        req.num = 40'({a, 8'b0}) - 40'(a);
        req.den = 32'(8'd255 - b);
      end
      pbo_pkg::MODE_BURN: begin
        req.num = 40'({~a, 8'b0}) - 40'(8'd255 - a);
        req.den = 32'(b);
      end
      pbo_pkg::MODE_SOFT_LIGHT: begin
        if (!b[7]) begin
          req.num = 40'(t) + pbo_pkg::SQ255_BIAS;
          req.den = pbo_pkg::SQ255;
        end else if (a[7:6] == 2'b00) begin
          req.num = 40'(x2);
          req.den = 32'(pbo_pkg::CUBE);
        end else begin
          req.num = 40'(x3);
          req.den = pbo_pkg::SOFT_DEN;
        end
      end
      default: begin
      end
    endcase
    return req;
  endfunction

  // Turns the divider result back into the blended channel value.
  function automatic logic [7:0] blend_post(input logic [3:0] mode, input logic [7:0] a,
                                            input logic [7:0] b, input logic [7:0] q,
                                            input logic sat);
    logic [8:0] sum;
    logic [8:0] up;
    logic [7:0] res;
    sum = 9'(a) + 9'(b);
    up  = 9'(a) + 9'(q);
    res = b;
    unique case (mode)
      pbo_pkg::MODE_MULTIPLY:   res = q;
      pbo_pkg::MODE_SCREEN:     res = ~q;
      pbo_pkg::MODE_OVERLAY:    res = a[7] ? ~q : q;
      pbo_pkg::MODE_HARD_LIGHT: res = b[7] ? ~q : q;
      pbo_pkg::MODE_SOFT_LIGHT: begin
        if (!b[7]) res = a - q;
        else       res = up[8] ? 8'd255 : up[7:0];
      end
      pbo_pkg::MODE_DODGE:      res = sat ? 8'd255 : q;
      pbo_pkg::MODE_BURN:       res = sat ? 8'd0 : ~q;
      pbo_pkg::MODE_LIN_DODGE:  res = sum[8] ? 8'd255 : sum[7:0];
      pbo_pkg::MODE_LIN_BURN:   res = (sum >= 9'd255) ? 8'(sum - 9'd255) : 8'd0;
      pbo_pkg::MODE_DARKEN:     res = (a < b) ? a : b;
      pbo_pkg::MODE_LIGHTEN:    res = (a > b) ? a : b;
      pbo_pkg::MODE_DIFFERENCE: res = (a > b) ? a - b : b - a;
      pbo_pkg::MODE_EXCLUSION:  res = 8'(10'(a) + 10'(b) - 10'({q, 1'b0}));
      default:                  res = b;
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stage 0: input register. Channel index 0 is red, 1 green, 2 blue.
  // ---------------------------------------------------------------------------
  logic [2:0][7:0] src0_q, dst0_q;
  logic [7:0]      sa0_q, da0_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      src0_q <= {pix_i.data.src_blue, pix_i.data.src_green, pix_i.data.src_red};
      dst0_q <= {pix_i.data.dst_blue, pix_i.data.dst_green, pix_i.data.dst_red};
      sa0_q  <= pix_i.data.src_alpha;
      da0_q  <= pix_i.data.dst_alpha;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: operand selection for the multiply family, first products of
  // the soft light polynomials, square root lookup, and source alpha times
  // layer opacity.
  // ---------------------------------------------------------------------------
  logic [2:0][7:0]  x1, y1;
  logic [2:0][16:0] rt1;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rt1[c] = pbo_pkg::ROOT_TAB[dst0_q[c]];
      x1[c]  = dst0_q[c];
      y1[c]  = src0_q[c];
      unique case (mode_q)
        pbo_pkg::MODE_SCREEN: begin
          x1[c] = ~dst0_q[c];
          y1[c] = ~src0_q[c];
        end
        pbo_pkg::MODE_OVERLAY: begin
          if (dst0_q[c][7]) begin
            x1[c] = 8'(9'd510 - {dst0_q[c], 1'b0});
            y1[c] = ~src0_q[c];
          end else begin
            x1[c] = {dst0_q[c][6:0], 1'b0};
          end
        end
        pbo_pkg::MODE_HARD_LIGHT: begin
          if (src0_q[c][7]) begin
            x1[c] = ~dst0_q[c];
            y1[c] = 8'(9'd510 - {src0_q[c], 1'b0});
          end else begin
            y1[c] = {src0_q[c][6:0], 1'b0};
          end
        end
        default: begin
        end
      endcase
    end
  end

  logic [2:0][7:0]  a1_q, b1_q, w1_q, m1_q;
  logic [2:0][15:0] prod1_q, asq1_q;
  logic [2:0][13:0] aa1_q;
  logic [2:0][21:0] diff1_q;
  logic [15:0]      sal1_q;
  logic [7:0]       da1_q;
  logic             az1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        a1_q[c]    <= dst0_q[c];
        b1_q[c]    <= src0_q[c];
        prod1_q[c] <= 16'(x1[c]) * 16'(y1[c]);
        aa1_q[c]   <= 14'(16'(dst0_q[c]) * 16'(8'd255 - dst0_q[c]));
        asq1_q[c]  <= 16'(dst0_q[c]) * 16'(dst0_q[c]);
        diff1_q[c] <= 22'(25'({rt1[c], 8'b0}) - 25'(rt1[c]) - 25'({dst0_q[c], 16'b0}));
        // 255 - 2b for a dark source, 2b - 255 for a light one.
        w1_q[c]    <= ~{src0_q[c][6:0], 1'b0};
        m1_q[c]    <= {src0_q[c][6:0], 1'b1};
      end
      sal1_q <= 16'(sa0_q) * 16'(layer_q);
      da1_q  <= da0_q;
      az1_q  <= (sa0_q == 8'd0);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: dark soft light term, cubic coefficient, light soft light term
  // for bright destinations, and the full effective source alpha S.
  // ---------------------------------------------------------------------------
  logic [2:0][7:0]  a2_q, b2_q, m2_q;
  logic [2:0][15:0] prod2_q;
  logic [2:0][21:0] t2_q;
  logic [2:0][18:0] cq2_q;
  logic [2:0][29:0] x3_2_q;
  logic [23:0]      s2_q;
  logic [7:0]       da2_q;
  logic             az2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        a2_q[c]    <= a1_q[c];
        b2_q[c]    <= b1_q[c];
        m2_q[c]    <= m1_q[c];
        prod2_q[c] <= prod1_q[c];
        t2_q[c]    <= 22'(22'(w1_q[c]) * 22'(aa1_q[c]));
        cq2_q[c]   <= 19'(21'({asq1_q[c], 4'b0}) + 21'd195075
                          - 21'(21'(a1_q[c]) * 21'd3060));
        x3_2_q[c]  <= 30'(30'(m1_q[c]) * 30'(diff1_q[c]));
      end
      s2_q  <= 24'(24'(sal1_q) * 24'(fill_q));
      da2_q <= da1_q;
      az2_q <= az1_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: cubic polynomial for dark destinations, 255*S and K-S.
  // ---------------------------------------------------------------------------
  logic [2:0][7:0]  a3_q, b3_q, m3_q;
  logic [2:0][15:0] prod3_q;
  logic [2:0][21:0] t3_q;
  logic [2:0][23:0] p3_q;
  logic [2:0][29:0] x3_3_q;
  logic [31:0]      s255_3_q;
  logic [23:0]      ks3_q;
  logic [7:0]       da3_q;
  logic             az3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        a3_q[c]    <= a2_q[c];
        b3_q[c]    <= b2_q[c];
        m3_q[c]    <= m2_q[c];
        prod3_q[c] <= prod2_q[c];
        t3_q[c]    <= t2_q[c];
        x3_3_q[c]  <= x3_2_q[c];
        // Only used for destinations below 64, where it fits 24 bits.
        p3_q[c]    <= 24'(27'(a2_q[c]) * 27'(cq2_q[c]));
      end
      s255_3_q <= 32'({s2_q, 8'b0}) - 32'(s2_q);
      ks3_q    <= pbo_pkg::CUBE - s2_q;
      da3_q    <= da2_q;
      az3_q    <= az2_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: scaled cubic term and D*(K-S).
  // ---------------------------------------------------------------------------
  logic [2:0][7:0]  a4_q, b4_q;
  logic [2:0][15:0] prod4_q;
  logic [2:0][21:0] t4_q;
  logic [2:0][31:0] x2_4_q;
  logic [2:0][29:0] x3_4_q;
  logic [31:0]      s255_4_q, dks4_q;
  logic [7:0]       da4_q;
  logic             az4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        a4_q[c]    <= a3_q[c];
        b4_q[c]    <= b3_q[c];
        prod4_q[c] <= prod3_q[c];
        t4_q[c]    <= t3_q[c];
        x3_4_q[c]  <= x3_3_q[c];
        x2_4_q[c]  <= 32'(32'(m3_q[c]) * 32'(p3_q[c]));
      end
      s255_4_q <= s255_3_q;
      dks4_q   <= 32'(32'(da3_q) * 32'(ks3_q));
      da4_q    <= da3_q;
      az4_q    <= az3_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Blend divider, one per color channel, with the side data delayed to match.
  // ---------------------------------------------------------------------------
  div_req_t [2:0]  breq;
  logic [2:0][7:0] bq;
  logic [2:0]      bsat;
  side_t           side_q [NS];

  for (genvar c = 0; c < 3; c++) begin : g_bdiv
    assign breq[c] = blend_req(mode_q, a4_q[c], b4_q[c], prod4_q[c], t4_q[c],
                               x2_4_q[c], x3_4_q[c]);
    pbo_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (breq[c].num),
      .den_i (breq[c].den),
      .quo_o (bq[c]),
      .sat_o (bsat[c])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= '{dst: a4_q, src: b4_q, da: da4_q, az: az4_q,
                     s255: s255_4_q, dks: dks4_q};
      for (int k = 1; k < NS; k++) side_q[k] <= side_q[k-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 13: blended value per channel and composite alpha O = 255S + D(K-S).
  // ---------------------------------------------------------------------------
  logic [2:0][7:0] bl13_q, dst13_q;
  logic [31:0]     o13_q, s255_13_q, dks13_q;
  logic [7:0]      da13_q;
  logic            az13_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        bl13_q[c] <= blend_post(mode_q, side_q[NS-1].dst[c], side_q[NS-1].src[c],
                                bq[c], bsat[c]);
      end
      dst13_q   <= side_q[NS-1].dst;
      o13_q     <= side_q[NS-1].s255 + side_q[NS-1].dks;
      s255_13_q <= side_q[NS-1].s255;
      dks13_q   <= side_q[NS-1].dks;
      da13_q    <= side_q[NS-1].da;
      az13_q    <= side_q[NS-1].az;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 14: the two weighted terms of each channel numerator.
  // ---------------------------------------------------------------------------
  logic [2:0][39:0] ms14_q, md14_q;
  logic [2:0][7:0]  dst14_q;
  logic [31:0]      o14_q;
  logic [7:0]       da14_q;
  logic             az14_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        ms14_q[c] <= 40'(bl13_q[c]) * 40'(s255_13_q);
        md14_q[c] <= 40'(dst13_q[c]) * 40'(dks13_q);
      end
      dst14_q <= dst13_q;
      o14_q   <= o13_q;
      da14_q  <= da13_q;
      az14_q  <= az13_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 15: channel numerators and the pass-through decision. A transparent
  // source, or an empty composite alpha, leaves the destination untouched.
  // ---------------------------------------------------------------------------
  logic [2:0][39:0] num15_q;
  logic [31:0]      o15_q;
  fin_t             fin15_q;
  fin_t             fin_q [NS];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 3; c++) num15_q[c] <= ms14_q[c] + md14_q[c];
      o15_q   <= o14_q;
      fin15_q <= '{dst: dst14_q, da: da14_q, skip: az14_q || (o14_q == 32'd0)};
    end
  end

  // ---------------------------------------------------------------------------
  // Composite divider: three color quotients over O and the alpha over K.
  // ---------------------------------------------------------------------------
  logic [3:0][7:0] fq;
  logic [3:0]      fsat;

  for (genvar c = 0; c < 3; c++) begin : g_fdiv
    pbo_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num15_q[c]),
      .den_i (o15_q),
      .quo_o (fq[c]),
      .sat_o (fsat[c])
    );
  end

  pbo_div u_adiv (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (40'(o15_q)),
    .den_i (32'(pbo_pkg::CUBE)),
    .quo_o (fq[3]),
    .sat_o (fsat[3])
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      fin_q[0] <= fin15_q;
      for (int k = 1; k < NS; k++) fin_q[k] <= fin_q[k-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Output: saturation and pass-through select on the last pipeline registers.
  // ---------------------------------------------------------------------------
  logic [3:0][7:0] res;

  always_comb begin
    for (int c = 0; c < 4; c++) res[c] = fsat[c] ? 8'd255 : fq[c];
  end

  assign pix_o.valid = v_q[LAT-1];
  assign pix_o.data.out_red   = fin_q[NS-1].skip ? fin_q[NS-1].dst[0] : res[0];
  assign pix_o.data.out_green = fin_q[NS-1].skip ? fin_q[NS-1].dst[1] : res[1];
  assign pix_o.data.out_blue  = fin_q[NS-1].skip ? fin_q[NS-1].dst[2] : res[2];
  assign pix_o.data.out_alpha = fin_q[NS-1].skip ? fin_q[NS-1].da : res[3];
  assign pix_o.data.changed   = !fin_q[NS-1].skip;

endmodule
